>>> rtl/lcdx_pkg.sv
// Shared types, command codes and LCD constants for the expander byte sequencer.
`default_nettype none

package lcdx_pkg;

	// Request and result transactions
	typedef struct packed {
		logic [2:0] command;
		logic [7:0] value;
		logic [1:0] row;
	} req_t;

	typedef struct packed {
		logic [7:0] expander_byte;
		logic [5:0] pre_delay_ms;
		logic [2:0] post_delay_ms;
		logic       last;
	} rsp_t;

	// Request command codes
	localparam logic [2:0] CMD_DATA      = 3'd0;
	localparam logic [2:0] CMD_BYTE      = 3'd1;
	localparam logic [2:0] CMD_CURSOR    = 3'd2;
	localparam logic [2:0] CMD_BACKLIGHT = 3'd3;
	localparam logic [2:0] CMD_INIT      = 3'd4;

	// Classified job passed from front to back
	typedef enum logic [1:0] {
		JOB_DATA      = 2'd0,
		JOB_CMD       = 2'd1,
		JOB_BACKLIGHT = 2'd2,
		JOB_INIT      = 2'd3
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] value;
		logic [2:0] post;
	} job_t;

	// HD44780 instruction bytes
	localparam logic [7:0] INSTR_CLEAR    = 8'h01;
	localparam logic [7:0] INSTR_HOME     = 8'h02;
	localparam logic [7:0] LCD_SET_DDRAM  = 8'h80;
	localparam logic [7:0] LCD_FUNC_4BIT  = 8'h28;
	localparam logic [7:0] LCD_DISP_OFF   = 8'h08;
	localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
	localparam logic [7:0] LCD_DISP_ON    = 8'h0C;
	localparam logic [3:0] NIB_WAKE       = 4'h3;
	localparam logic [3:0] NIB_4BIT       = 4'h2;

	// Delays in ms
	localparam logic [5:0] PRE_INIT_MS     = 6'd50;
	localparam logic [2:0] POST_CLEAR_MS   = 3'd2;
	localparam logic [2:0] POST_INIT_CLR_MS = 3'd4;

	// Sequencer step counts (index of final byte)
	localparam logic [4:0] LAST_STEP_BYTE = 5'd3;
	localparam logic [4:0] LAST_STEP_BL   = 5'd0;
	localparam logic [4:0] LAST_STEP_INIT = 5'd28;
	localparam logic [4:0] INIT_CMD_STEP0 = 5'd9;
	localparam logic [2:0] INIT_CLR_SLOT  = 3'd2;

	// Expander pin masks per layout
	localparam logic [7:0] BL_PIN_L0 = 8'h10;
	localparam logic [7:0] EN_PIN_L0 = 8'h20;
	localparam logic [7:0] RS_PIN_L0 = 8'h80;
	localparam logic [7:0] BL_PIN_L1 = 8'h08;
	localparam logic [7:0] EN_PIN_L1 = 8'h04;
	localparam logic [7:0] RS_PIN_L1 = 8'h01;

	// DDRAM base address of each row
	function automatic logic [7:0] ddram_base(input logic [1:0] row);
		logic [7:0] b;
		case (row)
			2'd0: b = 8'h00;
			2'd1: b = 8'h40;
			2'd2: b = 8'h14;
			2'd3: b = 8'h54;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// Command issued in each slot of the init sequence
	function automatic logic [7:0] init_cmd(input logic [2:0] slot);
		logic [7:0] c;
		case (slot)
			3'd0: c = LCD_FUNC_4BIT;
			3'd1: c = LCD_DISP_OFF;
			3'd2: c = INSTR_CLEAR;
			3'd3: c = LCD_ENTRY_MODE;
			3'd4: c = LCD_DISP_ON;
			default: c = LCD_DISP_ON;
		endcase
		return c;
	endfunction

	// Post delay after each wake-up nibble of init
	function automatic logic [2:0] wake_post(input logic [1:0] pair);
		logic [2:0] p;
		case (pair)
			2'd0: p = 3'd5;
			2'd1: p = 3'd5;
			2'd2: p = 3'd1;
			2'd3: p = 3'd0;
			default: p = 3'd0;
		endcase
		return p;
	endfunction

	// Assemble one expander byte from the LCD signals
	function automatic logic [7:0] pack_pins(input logic layout, input logic bl,
		input logic rs, input logic en, input logic [3:0] nib);
		logic [7:0] b;
		if (layout) begin
			b = {nib, 4'h0};
			if (bl) b = b | BL_PIN_L1;
			if (rs) b = b | RS_PIN_L1;
			if (en) b = b | EN_PIN_L1;
		end else begin
			b = {4'h0, nib};
			if (bl) b = b | BL_PIN_L0;
			if (rs) b = b | RS_PIN_L0;
			if (en) b = b | EN_PIN_L0;
		end
		return b;
	endfunction

endpackage

`default_nettype wire

>>> rtl/lcdx_front.sv
// Front end: accepts requests and classifies them into sequencer jobs.
`default_nettype none

module lcdx_front (
	input  wire logic          push,
	input  wire logic          full,
	input  wire lcdx_pkg::req_t req,
	output lcdx_pkg::job_t     job,
	output logic               job_push
);

	logic       valid_cmd;
	logic [7:0] cursor_addr;

	assign cursor_addr = lcdx_pkg::LCD_SET_DDRAM | (lcdx_pkg::ddram_base(req.row) + req.value);

	// Classify; unused codes are accepted and dropped
	always_comb begin
		valid_cmd = 1'b1;
		job.kind  = lcdx_pkg::JOB_DATA;
		job.value = req.value;
		job.post  = 3'd0;
		case (req.command)
			lcdx_pkg::CMD_DATA: begin
				job.kind = lcdx_pkg::JOB_DATA;
			end
			lcdx_pkg::CMD_BYTE: begin
				job.kind = lcdx_pkg::JOB_CMD;
				if (req.value == lcdx_pkg::INSTR_CLEAR || req.value == lcdx_pkg::INSTR_HOME)
					job.post = lcdx_pkg::POST_CLEAR_MS;
			end
			lcdx_pkg::CMD_CURSOR: begin
				job.kind  = lcdx_pkg::JOB_CMD;
				job.value = cursor_addr;
			end
			lcdx_pkg::CMD_BACKLIGHT: begin
				job.kind  = lcdx_pkg::JOB_BACKLIGHT;
				job.value = {7'd0, (req.value != 8'd0)};
			end
			lcdx_pkg::CMD_INIT: begin
				job.kind = lcdx_pkg::JOB_INIT;
			end
			default: begin
				valid_cmd = 1'b0;
			end
		endcase
	end

	assign job_push = push && !full && valid_cmd;

endmodule

`default_nettype wire

>>> rtl/lcdx_job_fifo.sv
// Small flop-based queue of classified jobs between front and back.
`default_nettype none

module lcdx_job_fifo #(
	parameter int DEPTH = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire lcdx_pkg::job_t wr_job,
	output logic                full,
	output logic                not_empty,
	input  wire logic           rd_en,
	output lcdx_pkg::job_t      rd_job
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	lcdx_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_job    = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_job;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (rd_en) rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (wr_en && !rd_en) count_q <= count_q + 1'b1;
			else if (!wr_en && rd_en) count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> rtl/lcdx_back.sv
// Back end: expands the head job into expander bytes, one per cycle while pop keeps up.
`default_nettype none

module lcdx_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic           cfg_wdata,
	input  wire logic           job_valid,
	input  wire lcdx_pkg::job_t job,
	output logic                job_pop,
	output logic                rsp_valid,
	output lcdx_pkg::rsp_t      rsp,
	input  wire logic           pop
);

	logic           layout_q;
	logic           bl_q;
	logic [4:0]     step_q;
	logic           out_valid_q;
	lcdx_pkg::rsp_t rsp_q;

	logic           advance;
	logic           is_last;
	logic [4:0]     last_step;
	lcdx_pkg::rsp_t nxt;

	// Layout register and backlight state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q <= 1'b0;
			bl_q     <= 1'b0;
		end else begin
			if (cfg_we) layout_q <= cfg_wdata;
			if (advance && job.kind == lcdx_pkg::JOB_BACKLIGHT) bl_q <= job.value[0];
			if (advance && job.kind == lcdx_pkg::JOB_INIT) bl_q <= 1'b1;
		end
	end

	// Step bookkeeping
	always_comb begin
		case (job.kind)
			lcdx_pkg::JOB_INIT:      last_step = lcdx_pkg::LAST_STEP_INIT;
			lcdx_pkg::JOB_BACKLIGHT: last_step = lcdx_pkg::LAST_STEP_BL;
			default:                 last_step = lcdx_pkg::LAST_STEP_BYTE;
		endcase
	end

	assign advance = job_valid && (!out_valid_q || pop);
	assign is_last = (step_q == last_step);
	assign job_pop = advance && is_last;

	// Byte for the current step
	always_comb begin
		logic [4:0] m;
		logic [2:0] k;
		logic [7:0] icmd;
		logic [3:0] nib;
		m    = step_q - lcdx_pkg::INIT_CMD_STEP0;
		k    = 3'(step_q - 5'd1);
		icmd = lcdx_pkg::init_cmd(m[4:2]);
		nib  = 4'd0;
		nxt.expander_byte = 8'd0;
		nxt.pre_delay_ms  = 6'd0;
		nxt.post_delay_ms = 3'd0;
		nxt.last          = is_last;
		case (job.kind)
			lcdx_pkg::JOB_DATA, lcdx_pkg::JOB_CMD: begin
				nib = step_q[1] ? job.value[3:0] : job.value[7:4];
				nxt.expander_byte = lcdx_pkg::pack_pins(layout_q, bl_q,
					job.kind == lcdx_pkg::JOB_DATA, !step_q[0], nib);
				if (is_last) nxt.post_delay_ms = job.post;
			end
			lcdx_pkg::JOB_BACKLIGHT: begin
				nxt.expander_byte = lcdx_pkg::pack_pins(layout_q, job.value[0],
					1'b0, 1'b0, 4'd0);
			end
			lcdx_pkg::JOB_INIT: begin
				if (step_q == 5'd0) begin
					// backlight-only byte after the power-up wait
					nxt.expander_byte = lcdx_pkg::pack_pins(layout_q, 1'b1, 1'b0, 1'b0, 4'd0);
					nxt.pre_delay_ms  = lcdx_pkg::PRE_INIT_MS;
				end else if (step_q < lcdx_pkg::INIT_CMD_STEP0) begin
					// wake-up nibbles 3,3,3 then 2
					nib = (k[2:1] == 2'd3) ? lcdx_pkg::NIB_4BIT : lcdx_pkg::NIB_WAKE;
					nxt.expander_byte = lcdx_pkg::pack_pins(layout_q, 1'b1, 1'b0, !k[0], nib);
					if (k[0]) nxt.post_delay_ms = lcdx_pkg::wake_post(k[2:1]);
				end else begin
					// configuration commands
					nib = m[1] ? icmd[3:0] : icmd[7:4];
					nxt.expander_byte = lcdx_pkg::pack_pins(layout_q, 1'b1, 1'b0, !m[0], nib);
					if (m[1:0] == 2'd3 && m[4:2] == lcdx_pkg::INIT_CLR_SLOT)
						nxt.post_delay_ms = lcdx_pkg::POST_INIT_CLR_MS;
				end
			end
			default: begin
				nxt.expander_byte = 8'd0;
			end
		endcase
	end

	// Step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				step_q      <= is_last ? 5'd0 : step_q + 5'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (advance) rsp_q <= nxt;
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

>>> rtl/char_lcd_expander_byte_sequencer.sv
// Top level: LCD request queue in, expander byte queue out.
`default_nettype none

// Turns character-LCD requests (data char, command byte, set cursor, set backlight,
// init) into the bytes written to an 8-bit port expander driving a 4-bit HD44780.
// A request enters when push is high and full low; codes 5..7 are taken and dropped.
// Results come out one byte per transaction, oldest first, while empty is low.
// The back sequencer emits at most one byte per cycle from its output register; a data,
// command or cursor request gives 4 bytes, a backlight request 1 and init 29. Up to
// JOB_DEPTH classified requests wait in between, so the input side keeps taking
// requests while bytes of an earlier one drain.
// cfg_wdata selects the pin layout and may be written only while the block is idle.
module char_lcd_expander_byte_sequencer #(
	parameter int JOB_DEPTH = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire lcdx_pkg::req_t req,
	output logic                empty,
	input  wire logic           pop,
	output lcdx_pkg::rsp_t      rsp,
	input  wire logic           cfg_we,
	input  wire logic           cfg_wdata
);

	lcdx_pkg::job_t front_job;
	lcdx_pkg::job_t head_job;
	logic           job_push;
	logic           job_pop;
	logic           job_valid;
	logic           rsp_valid;

	// Classify incoming requests
	lcdx_front u_front (
		.push     (push),
		.full     (full),
		.req      (req),
		.job      (front_job),
		.job_push (job_push)
	);

	// Job queue decouples front from back
	lcdx_job_fifo #(
		.DEPTH (JOB_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (job_push),
		.wr_job    (front_job),
		.full      (full),
		.not_empty (job_valid),
		.rd_en     (job_pop),
		.rd_job    (head_job)
	);

	// Byte sequencer
	lcdx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.job_valid (job_valid),
		.job       (head_job),
		.job_pop   (job_pop),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.pop       (pop)
	);

	assign empty = !rsp_valid;

endmodule

`default_nettype wire

>>> rtl/lcdx_checker.sv
// Port-level checker for the expander byte sequencer, bound to the top level.
`default_nettype none

module lcdx_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           empty,
	input wire logic           pop,
	input wire lcdx_pkg::rsp_t rsp
);

	// A waiting result stays until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result dropped without pop");

	// A waiting result keeps its value
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(rsp))
		else $error("result changed while waiting");

	// Only the init lead-in byte carries a pre delay
	a_pre: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (rsp.pre_delay_ms == 6'd0 || rsp.pre_delay_ms == lcdx_pkg::PRE_INIT_MS))
		else $error("unexpected pre delay");

	// The init lead-in byte never ends a transaction group and has no post delay
	a_lead: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && rsp.pre_delay_ms == lcdx_pkg::PRE_INIT_MS |->
			!rsp.last && rsp.post_delay_ms == 3'd0)
		else $error("bad init lead-in byte");

endmodule

bind char_lcd_expander_byte_sequencer lcdx_checker u_lcdx_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.rsp    (rsp)
);

`default_nettype wire

>>> tb/lcd_byte_checker.sv
// Checker for the LCD expander byte sequencer: predicts every expander byte and compares.
module lcd_byte_checker
	import lcdx_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire logic full,
	input  wire req_t req,
	input  wire logic empty,
	input  wire logic pop,
	input  wire rsp_t rsp,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata,
	output int        fail_count,
	output int        outstanding
);

	// DDRAM address of column 0 on each row
	localparam logic [7:0] ROW_START [4] = '{8'h00, 8'h40, 8'h14, 8'h54};
	// Wait after the enable-low byte of each wake-up nibble of init
	localparam logic [2:0] WAKE_POST [4] = '{3'd5, 3'd5, 3'd1, 3'd0};
	// Instructions sent at the end of init
	localparam logic [7:0] INIT_SEQ [5] = '{LCD_FUNC_4BIT, LCD_DISP_OFF, INSTR_CLEAR,
		LCD_ENTRY_MODE, LCD_DISP_ON};

	logic layout_sel;
	logic backlight_state;
	rsp_t expected_bytes [$];

	// Backlight pin of the current layout
	function automatic logic [7:0] bl_mask();
		return layout_sel ? BL_PIN_L1 : BL_PIN_L0;
	endfunction

	// Port byte for one nibble with the given RS and EN levels
	function automatic logic [7:0] port_byte(input logic rs, input logic en,
		input logic [3:0] nib);
		logic [7:0] en_m;
		logic [7:0] rs_m;
		logic [7:0] b;
		en_m = layout_sel ? EN_PIN_L1 : EN_PIN_L0;
		rs_m = layout_sel ? RS_PIN_L1 : RS_PIN_L0;
		b = layout_sel ? {nib, 4'h0} : {4'h0, nib};
		if (backlight_state) b = b | bl_mask();
		if (rs) b = b | rs_m;
		if (en) b = b | en_m;
		return b;
	endfunction

	function automatic void queue_byte(input logic [7:0] b, input logic [5:0] pre,
		input logic [2:0] post);
		rsp_t r;
		r.expander_byte = b;
		r.pre_delay_ms  = pre;
		r.post_delay_ms = post;
		r.last          = 1'b0;
		expected_bytes.push_back(r);
	endfunction

	// One nibble is an enable-high byte followed by an enable-low byte
	function automatic void queue_nibble(input logic [3:0] nib, input logic rs,
		input logic [2:0] post);
		queue_byte(port_byte(rs, 1'b1, nib), 6'd0, 3'd0);
		queue_byte(port_byte(rs, 1'b0, nib), 6'd0, post);
	endfunction

	function automatic void queue_lcd_byte(input logic [7:0] v, input logic rs,
		input logic [2:0] post);
		queue_nibble(v[7:4], rs, 3'd0);
		queue_nibble(v[3:0], rs, post);
	endfunction

	// Clear and home need extra settle time after the final byte
	function automatic void queue_instruction(input logic [7:0] cmd, input logic [2:0] extra);
		logic [2:0] post;
		post = extra;
		if (cmd == INSTR_CLEAR || cmd == INSTR_HOME) post = post + POST_CLEAR_MS;
		queue_lcd_byte(cmd, 1'b0, post);
	endfunction

	function automatic void predict_request(input req_t r);
		int         size_at_entry;
		logic [7:0] addr;
		rsp_t       tail;
		size_at_entry = expected_bytes.size();
		case (r.command)
			CMD_DATA: begin
				queue_lcd_byte(r.value, 1'b1, 3'd0);
			end
			CMD_BYTE: begin
				queue_instruction(r.value, 3'd0);
			end
			CMD_CURSOR: begin
				// address wraps at 8 bits
				addr = ROW_START[r.row] + r.value;
				queue_instruction(LCD_SET_DDRAM | addr, 3'd0);
			end
			CMD_BACKLIGHT: begin
				backlight_state = (r.value != 8'h00);
				queue_byte(backlight_state ? bl_mask() : 8'h00, 6'd0, 3'd0);
			end
			CMD_INIT: begin
				backlight_state = 1'b1;
				queue_byte(bl_mask(), PRE_INIT_MS, 3'd0);
				for (int i = 0; i < 3; i++) queue_nibble(NIB_WAKE, 1'b0, WAKE_POST[i]);
				queue_nibble(NIB_4BIT, 1'b0, WAKE_POST[3]);
				// the clear inside init waits 2 ms longer than a plain clear
				for (int i = 0; i < 5; i++)
					queue_instruction(INIT_SEQ[i], (INIT_SEQ[i] == INSTR_CLEAR) ? 3'd2 : 3'd0);
			end
			default: begin
				// unused codes produce nothing and keep the state
			end
		endcase
		if (expected_bytes.size() > size_at_entry) begin
			tail = expected_bytes.pop_back();
			tail.last = 1'b1;
			expected_bytes.push_back(tail);
		end
	endfunction

	function automatic void note_mismatch(input string field, input logic [7:0] want,
		input logic [7:0] got);
		$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
	endfunction

	// Sample both channels and the config port at each clock edge
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			layout_sel      = 1'b0;
			backlight_state = 1'b0;
			expected_bytes.delete();
			fail_count      = 0;
			outstanding     = 0;
		end else begin
			if (cfg_we) layout_sel = cfg_wdata;
			if (pop && !empty) begin
				if (expected_bytes.size() == 0) begin
					fail_count++;
					note_mismatch("unexpected transaction, byte", 8'h00, rsp.expander_byte);
				end else begin
					want = expected_bytes.pop_front();
					if (rsp !== want) begin
						fail_count++;
						if (rsp.expander_byte !== want.expander_byte)
							note_mismatch("expander_byte", want.expander_byte, rsp.expander_byte);
						if (rsp.pre_delay_ms !== want.pre_delay_ms)
							note_mismatch("pre_delay_ms", 8'(want.pre_delay_ms),
								8'(rsp.pre_delay_ms));
						if (rsp.post_delay_ms !== want.post_delay_ms)
							note_mismatch("post_delay_ms", 8'(want.post_delay_ms),
								8'(rsp.post_delay_ms));
						if (rsp.last !== want.last)
							note_mismatch("last", 8'(want.last), 8'(rsp.last));
					end
				end
			end
			if (push && !full) predict_request(req);
			outstanding = expected_bytes.size();
		end
	end

endmodule

>>> tb/testbench.sv
// Top of the LCD expander byte sequencer test: clock, reset, stimulus and verdict.
module testbench;
	import lcdx_pkg::*;

	localparam int         CYCLE_LIMIT     = 1_000_000;
	localparam int         ITEMS_PER_PHASE = 105;
	localparam int         SETTLE_CYCLES   = 16;
	localparam logic [2:0] CMD_UNUSED_LO   = 3'd5;
	localparam logic [2:0] CMD_UNUSED_MID  = 3'd6;
	localparam logic [2:0] CMD_UNUSED_HI   = 3'd7;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic push      = 1'b0;
	logic pop       = 1'b0;
	logic cfg_we    = 1'b0;
	logic cfg_wdata = 1'b0;
	req_t req       = '0;
	logic full;
	logic empty;
	rsp_t rsp;
	int   fail_count;
	int   outstanding;
	int   cycles     = 0;
	int   push_burst = 0;
	int   pop_burst  = 0;

	char_lcd_expander_byte_sequencer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	lcd_byte_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.req         (req),
		.empty       (empty),
		.pop         (pop),
		.rsp         (rsp),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Idle cycles before the next transaction; occasional bursts with no idling
	function automatic int draw_gap(inout int burst);
		int g;
		if (burst > 0) begin
			burst--;
			g = 0;
		end else if ($urandom_range(0, 9) == 0) begin
			burst = $urandom_range(8, 40);
			g = 0;
		end else begin
			g = $urandom_range(0, 11);
		end
		return g;
	endfunction

	// Present one request and return at the edge that accepts it
	task automatic send_req(input logic [2:0] cmd, input logic [7:0] v, input logic [1:0] row);
		int gap;
		gap = draw_gap(push_burst);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		req  <= '{command: cmd, value: v, row: row};
		do @(posedge clk); while (full);
	endtask

	// Stop pushing and let the block drain completely
	task automatic settle();
		push <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_layout(input logic layout);
		cfg_we    <= 1'b1;
		cfg_wdata <= layout;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Extremes, every command, clear/home, cursor wrap, unused codes
	task automatic run_directed();
		send_req(CMD_BACKLIGHT, 8'h00, 2'd0);
		send_req(CMD_DATA, 8'h00, 2'd0);
		send_req(CMD_DATA, 8'hFF, 2'd3);
		send_req(CMD_BYTE, INSTR_CLEAR, 2'd0);
		send_req(CMD_BYTE, INSTR_HOME, 2'd1);
		send_req(CMD_BYTE, 8'h00, 2'd2);
		send_req(CMD_BYTE, 8'hFF, 2'd3);
		send_req(CMD_CURSOR, 8'h00, 2'd0);
		send_req(CMD_CURSOR, 8'h27, 2'd1);
		send_req(CMD_CURSOR, 8'hFF, 2'd2);
		send_req(CMD_CURSOR, 8'hAC, 2'd3);
		send_req(CMD_BACKLIGHT, 8'h80, 2'd0);
		send_req(CMD_DATA, 8'h5A, 2'd2);
		send_req(CMD_INIT, 8'hFF, 2'd3);
		send_req(CMD_UNUSED_LO, 8'hFF, 2'd3);
		send_req(CMD_UNUSED_MID, 8'h00, 2'd0);
		send_req(CMD_UNUSED_HI, 8'hA5, 2'd1);
		send_req(CMD_DATA, 8'hA5, 2'd1);
		send_req(CMD_BACKLIGHT, 8'h00, 2'd0);
		send_req(CMD_BYTE, 8'h03, 2'd0);
		send_req(CMD_BACKLIGHT, 8'h01, 2'd3);
	endtask

	// Random mix; unused codes are sent but not counted
	task automatic run_random(input int count);
		int         done;
		int         pick;
		logic [7:0] v;
		logic [1:0] row;
		done = 0;
		while (done < count) begin
			pick = $urandom_range(0, 99);
			v    = 8'($urandom_range(0, 255));
			row  = 2'($urandom_range(0, 3));
			if (pick < 30) begin
				send_req(CMD_DATA, v, row);
			end else if (pick < 55) begin
				if ($urandom_range(0, 2) == 0) v = $urandom_range(0, 1) ? INSTR_CLEAR : INSTR_HOME;
				send_req(CMD_BYTE, v, row);
			end else if (pick < 78) begin
				send_req(CMD_CURSOR, v, row);
			end else if (pick < 88) begin
				if ($urandom_range(0, 1) == 0) v = 8'h00;
				send_req(CMD_BACKLIGHT, v, row);
			end else if (pick < 94) begin
				send_req(CMD_INIT, v, row);
			end else begin
				send_req(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), v, row);
				done--;
			end
			done++;
		end
	endtask

	// Result side: random stalls on pop
	initial begin
		int gap;
		do @(posedge clk); while (!arst_n);
		forever begin
			gap = draw_gap(pop_burst);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	// Main sequence: layout alternates between phases, each change made while idle
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random(ITEMS_PER_PHASE);
		settle();
		write_layout(1'b1);
		run_random(ITEMS_PER_PHASE);
		settle();
		write_layout(1'b0);
		run_random(ITEMS_PER_PHASE);
		settle();
		write_layout(1'b1);
		run_random(ITEMS_PER_PHASE);
		settle();
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/lcdx_pkg.sv
rtl/lcdx_front.sv
rtl/lcdx_job_fifo.sv
rtl/lcdx_back.sv
rtl/char_lcd_expander_byte_sequencer.sv
rtl/lcdx_checker.sv
tb/lcd_byte_checker.sv
tb/testbench.sv
